>>> hw/rtl/akd_pkg.sv
// ----------------------------------------------------------------------------
// akd_pkg: shared types and constants for the ladder keypad debouncer
// Holds the key range table, the classifier function and the queue entry type.
// ----------------------------------------------------------------------------
package akd_pkg;

  localparam int SampleBits  = 12;
  localparam int NumRanges   = 6;
  localparam int TableRanges = 6;
  // Only ranges that are in the table can be tested.
  localparam int NumTested   = (NumRanges < TableRanges) ? NumRanges : TableRanges;

  localparam int RangeW      = 16;
  localparam int KeyW        = 3;
  localparam int TimeW       = 32;
  localparam int SettleW     = 16;

  localparam logic [SettleW-1:0] SettleReset = 16'd50;

  // Inclusive bounds; entry order is priority order (lowest index wins).
  localparam logic [RangeW-1:0] RangeLo [TableRanges] = '{
    16'd3666, 16'd2030, 16'd2701, 16'd3033, 16'd3221, 16'd3428
  };
  localparam logic [RangeW-1:0] RangeHi [TableRanges] = '{
    16'd4095, 16'd2078, 16'd2759, 16'd3107, 16'd3301, 16'd3513
  };

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] idx;
  } class_t;

  typedef struct packed {
    logic             hit;
    logic [KeyW-1:0]  idx;
    logic [TimeW-1:0] now;
  } entry_t;

  function automatic class_t classify(input logic [SampleBits-1:0] s);
    class_t           res;
    logic [RangeW-1:0] sx;
    res.hit = 1'b0;
    res.idx = '0;
    sx      = RangeW'(s);
    // Walk downward so the lowest matching index is the one kept.
    for (int i = NumTested - 1; i >= 0; i--) begin
      if (sx >= RangeLo[i] && sx <= RangeHi[i]) begin
        res.hit = 1'b1;
        res.idx = KeyW'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/adc_ladder_key_debounce.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_debounce: resistor-ladder keypad debouncer
// Classifies keypad ADC samples into key ranges and latches a stable key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample_i with its
//   now_ms_i timestamp per transfer. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result per input: pressed_key_o, the
//   latched key after this sample, and latched_now_o, set when this sample
//   performed the latch (also when the same key latches again).
//   The settle time is written through cfg_valid_i / cfg_settle_time_i;
//   cfg_ready_o is always high. Write it only while the block is idle.
//   A result is written into the front queue when its input transfers,
//   then loaded into the back end's output register, from which it can
//   transfer. Throughput: one item per cycle while the output is not
//   stalled; the debounce update (a 32-bit elapsed-time subtract and
//   compare) in the back end is combinational.
//   A two-entry queue between front and back means the input keeps taking
//   items for a while when the receiver stalls; in_stall_o rises only when
//   that queue is full. Results are held stable while stalled.
//   Reset: detector disarmed, key 0, settle time 50 ms, queue and output empty.
// ----------------------------------------------------------------------------
module adc_ladder_key_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [akd_pkg::SettleW-1:0]    cfg_settle_time_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [akd_pkg::SampleBits-1:0] sample_i,
  input  logic [akd_pkg::TimeW-1:0]      now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [akd_pkg::KeyW-1:0]       pressed_key_o,
  output logic                           latched_now_o
);

  logic            push, pop, q_full, q_not_empty;
  akd_pkg::entry_t push_data, head;

  assign cfg_ready_o = 1'b1;

  // Front: classify and push into the queue.
  akd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .now_ms_i    (now_ms_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouples input transfers from output stalls.
  akd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .head_o      (head)
  );

  // Back: debounce state machine and registered result.
  akd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_settle_time_i (cfg_settle_time_i),
    .not_empty_i       (q_not_empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pressed_key_o     (pressed_key_o),
    .latched_now_o     (latched_now_o)
  );

endmodule

>>> hw/rtl/akd_front.sv
// ----------------------------------------------------------------------------
// akd_front: input stage
// Takes samples, classifies them against the key ranges, forms queue entries.
// ----------------------------------------------------------------------------
module akd_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [akd_pkg::SampleBits-1:0] sample_i,
  input  logic [akd_pkg::TimeW-1:0]      now_ms_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output akd_pkg::entry_t                push_data_o
);

  akd_pkg::class_t cls;

  always_comb begin
    cls = akd_pkg::classify(sample_i);
  end

  assign in_stall_o       = q_full_i;
  assign push_o           = in_valid_i && !q_full_i;
  assign push_data_o.hit  = cls.hit;
  assign push_data_o.idx  = cls.idx;
  assign push_data_o.now  = now_ms_i;

endmodule

>>> hw/rtl/akd_queue.sv
// ----------------------------------------------------------------------------
// akd_queue: two-entry queue between front and back
// Lets the input side keep transferring while the back end waits on a stall.
// ----------------------------------------------------------------------------
module akd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  akd_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output akd_pkg::entry_t head_o
);

  akd_pkg::entry_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o      = cnt_q[1];
  assign not_empty_o = (cnt_q != 2'd0);
  assign head_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/akd_back.sv
// ----------------------------------------------------------------------------
// akd_back: debounce state and output register
// Applies the arm / latch / disarm rules and holds the result for transfer.
// ----------------------------------------------------------------------------
module akd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [akd_pkg::SettleW-1:0] cfg_settle_time_i,
  input  logic                        not_empty_i,
  input  akd_pkg::entry_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [akd_pkg::KeyW-1:0]    pressed_key_o,
  output logic                        latched_now_o
);

  logic [akd_pkg::SettleW-1:0] settle_q;
  logic                        armed_q, armed_d;
  logic [akd_pkg::TimeW-1:0]   start_q, start_d;
  logic [akd_pkg::KeyW-1:0]    det_q, det_d;
  logic [akd_pkg::KeyW-1:0]    key_q, key_d;
  logic                        out_valid_q, out_valid_d;
  logic [akd_pkg::KeyW-1:0]    out_key_q;
  logic                        out_lat_q;
  logic                        fire, lat;
  logic [akd_pkg::TimeW-1:0]   elapsed;

  assign fire    = not_empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = fire;
  assign elapsed = head_i.now - start_q;

  always_comb begin
    armed_d = armed_q;
    start_d = start_q;
    det_d   = det_q;
    key_d   = key_q;
    lat     = 1'b0;
    if (fire && head_i.hit) begin
      if (!armed_q) begin
        armed_d = 1'b1;
        start_d = head_i.now;
        det_d   = head_i.idx;
      end else if (head_i.idx == det_q) begin
        if (elapsed > akd_pkg::TimeW'(settle_q)) begin
          key_d   = head_i.idx;
          armed_d = 1'b0;
          lat     = 1'b1;
        end
      end else begin
        armed_d = 1'b0;
      end
    end
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q    <= akd_pkg::SettleReset;
      armed_q     <= 1'b0;
      start_q     <= '0;
      det_q       <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        settle_q <= cfg_settle_time_i;
      end
      armed_q     <= armed_d;
      start_q     <= start_d;
      det_q       <= det_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_key_q <= key_d;
      out_lat_q <= lat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pressed_key_o = out_key_q;
  assign latched_now_o = out_lat_q;

`ifndef NO_ASSERTIONS
  // A latch always disarms the detector.
  a_latch_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat |=> !armed_q)
    else $error("detector still armed after latch");

  // A shown latch result carries the key now held in state.
  a_out_matches_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lat_q) |-> (out_key_q == key_q))
    else $error("latched output disagrees with key state");

  // The armed range is always one the table can produce.
  a_det_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (det_q <= akd_pkg::KeyW'(akd_pkg::NumTested - 1)))
    else $error("armed range out of table");

  // Nothing is popped while a stalled result is still pending.
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("queue popped while output stalled");
`endif

endmodule
